// ===== src/bbcx_pkg.sv =====
// Shared types, constants and fixed-point helpers for the Butterworth biquad cascade.
// Used by bbcx_mul and butterworth_biquad_cascade_xfade; depends on nothing else.
`default_nettype none
package bbcx_pkg;
	localparam int SAMPLE_BITS = 24;
	localparam int COEF_BITS = 48;
	localparam int TAP_BITS = 56;
	localparam int COEF_COUNT = 17;
	localparam int MAX_SECTIONS = 8;

	localparam logic [1:0] OP_FRAME = 2'd0;
	localparam logic [1:0] OP_COEF = 2'd1;
	localparam logic [1:0] OP_APPLY = 2'd2;

	localparam logic [1:0] CFG_MODE = 2'd0;
	localparam logic [1:0] CFG_FRAMES = 2'd1;
	localparam logic [1:0] CFG_STEP = 2'd2;

	localparam logic [1:0] MODE_HIGH = 2'd1;

	localparam logic [16:0] ONE_Q16 = 17'h10000;

	localparam logic signed [57:0] TAP_MAX = 58'sh007FFFFFFFFFFFFF;
	localparam logic signed [57:0] TAP_MIN = -TAP_MAX - 58'sd1;

	typedef enum logic {SH_FRAC, SH_FADE} mshift_t;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [23:0] left_in;
		logic signed [23:0] right_in;
		logic [4:0]         coef_index;
		logic signed [47:0] coef_value;
	} in_word_t;

	typedef struct packed {
		logic signed [23:0] left_out;
		logic signed [23:0] right_out;
	} out_word_t;

	function automatic logic signed [55:0] sat_tap(input logic signed [57:0] v);
		logic signed [55:0] r;
		if (v > TAP_MAX) begin
			r = TAP_MAX[55:0];
		end else if (v < TAP_MIN) begin
			r = TAP_MIN[55:0];
		end else begin
			r = v[55:0];
		end
		return r;
	endfunction

	// Round Q12.44 to Q1.23 half away from zero, then saturate.
	function automatic logic signed [23:0] to_sample(input logic signed [55:0] y);
		logic [55:0] mag;
		logic [56:0] sum;
		logic [35:0] r;
		logic [23:0] o;
		mag = y[55] ? 56'(-y) : 56'(y);
		sum = {1'b0, mag} + 57'h100000;
		r = sum[56:21];
		if (!y[55]) begin
			o = (r > 36'h7FFFFF) ? 24'h7FFFFF : r[23:0];
		end else begin
			o = (r > 36'h800000) ? 24'h800000 : 24'(-r[23:0]);
		end
		return o;
	endfunction
endpackage
`default_nettype wire

// ===== src/butterworth_biquad_cascade_xfade.sv =====
// Stereo Butterworth biquad cascade with coefficient cross-fade, top level.
// Uses bbcx_pkg and the shared multiplier bbcx_mul.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   in_word  (in_word_t)
//   out      output     out_valid / out_stall out_word (out_word_t)
//   cfg      input      cfg_write             cfg_index, cfg_data
//
// A sample word runs both channels through the live cascade, and through the old one
// while a fade is active, one multiply at a time on the shared multiplier; the cascade
// has four sections, or eight when mode bit 1 is set. A coefficient write loads the
// staging bank; applying copies it into the new live bank and clears the new tap bank.
// After reset a clearing pass zeroes the coefficient and tap memories.
// in_stall is high whenever a word is in progress; out_stall only delays the final load.
`default_nettype none
module butterworth_biquad_cascade_xfade (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire bbcx_pkg::in_word_t    in_word,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output bbcx_pkg::out_word_t        out_word,
	input  wire logic                  cfg_write,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [15:0]           cfg_data
);
	import bbcx_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_COPY, ST_GAIN_RD, ST_GAIN_MUL, ST_GAIN_WAIT,
		ST_SEC_RD0, ST_SEC_RD1, ST_SEC_M1, ST_SEC_M2,
		ST_FADE_A, ST_FADE_AW, ST_FADE_B, ST_FADE_BW, ST_OUT
	} state_t;

	state_t state_q;
	logic [6:0] cnt_q;
	logic [1:0] pass_q;
	logic [2:0] sec_q;
	logic       fch_q;
	in_word_t   in_q;
	logic signed [55:0] x_q, old_q, new_q, w_q, y_q, a_q;
	logic signed [55:0] yc0_q, yc1_q, yo0_q, yo1_q;
	logic [1:0]  mode_q;
	logic [12:0] frames_q, ramp_count_q;
	logic [15:0] step_q;
	logic [16:0] mix_q;
	logic        ramp_active_q;
	logic        csel_q, tsel_q;
	logic        out_valid_q;
	out_word_t   out_q;

	// Coefficient memory: bank 0 staging, banks 1 and 2 alternate as live and old.
	logic signed [47:0] coef_mem [96];
	logic signed [47:0] coef_rd_q;
	logic [6:0]  coef_raddr, coef_waddr;
	logic        coef_we;
	logic signed [47:0] coef_wdata;

	// Tap memory: {bank, channel, entry}.
	logic signed [55:0] tap_mem [64];
	logic signed [55:0] tap_rd_q;
	logic [5:0]  tap_raddr, tap_waddr;
	logic        tap_we;
	logic signed [55:0] tap_wdata;

	logic        mul_start, mul_done;
	logic signed [55:0] mul_a, mul_b, mul_res;
	mshift_t     mul_sh;

	logic [1:0]  cbank, cur_cbank;
	logic        tbank, ch;
	logic [4:0]  cidx;
	logic [3:0]  tentry;
	logic signed [23:0] samp;
	logic [2:0]  last_sec;
	logic        hp;
	logic signed [57:0] twice;
	logic signed [55:0] w1, y1, w2, y2;
	logic [17:0] mix_sum;
	logic [12:0] count_next, limit;

	bbcx_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.sh(mul_sh), .res(mul_res), .done(mul_done)
	);

	always_comb begin
		cur_cbank = {csel_q, ~csel_q};
		cbank = pass_q[1] ? {~csel_q, csel_q} : cur_cbank;
		tbank = pass_q[1] ? ~tsel_q : tsel_q;
		ch = pass_q[0];
		samp = ch ? in_q.right_in : in_q.left_in;
		last_sec = mode_q[1] ? 3'(MAX_SECTIONS - 1) : 3'd3;
		hp = (mode_q == MODE_HIGH) || (mode_q[1] && !sec_q[2]);
		twice = {tap_rd_q[55], tap_rd_q, 1'b0};
		w1 = sat_tap(58'(x_q) - 58'(mul_res));
		y1 = hp ? sat_tap(58'(old_q) - twice) : sat_tap(58'(old_q) + twice);
		w2 = sat_tap(58'(w_q) - 58'(mul_res));
		y2 = sat_tap(58'(y_q) + 58'(w2));
		mix_sum = 18'(mix_q) + 18'(step_q);
		count_next = ramp_count_q + 13'd1;
		limit = (frames_q == 13'd0) ? 13'd1 : frames_q;

		if (state_q == ST_GAIN_RD) begin
			cidx = 5'd0;
		end else if (state_q == ST_SEC_RD0) begin
			cidx = {1'b0, sec_q, 1'b1};
		end else begin
			cidx = 5'({sec_q, 1'b0}) + 5'd2;
		end
		tentry = {sec_q, (state_q == ST_SEC_RD0) ? 1'b0 : 1'b1};
		coef_raddr = (state_q == ST_COPY) ? {2'b00, cnt_q[4:0]} : {cbank, cidx};
		tap_raddr = {tbank, ch, tentry};

		coef_we = 1'b0;
		coef_waddr = cnt_q;
		coef_wdata = '0;
		tap_we = 1'b0;
		tap_waddr = cnt_q[5:0];
		tap_wdata = '0;
		mul_start = 1'b0;
		mul_a = 56'(coef_rd_q);
		mul_b = tap_rd_q;
		mul_sh = SH_FRAC;

		case (state_q)
			ST_CLEAR: begin
				coef_we = 1'b1;
				tap_we = !cnt_q[6];
			end
			ST_IDLE: begin
				if (in_valid && in_word.op == OP_COEF && in_word.coef_index < 5'(COEF_COUNT)) begin
					coef_we = 1'b1;
					coef_waddr = {2'b00, in_word.coef_index};
					coef_wdata = in_word.coef_value;
				end
			end
			ST_COPY: begin
				coef_we = (cnt_q != 7'd0) && (cnt_q <= 7'(COEF_COUNT));
				coef_waddr = {cur_cbank, 5'(cnt_q - 7'd1)};
				coef_wdata = coef_rd_q;
				tap_we = (cnt_q[6:5] == 2'b00);
				tap_waddr = {tsel_q, cnt_q[4:0]};
			end
			ST_GAIN_MUL: begin
				mul_start = 1'b1;
				mul_b = {{11{samp[23]}}, samp, 21'd0};
			end
			ST_SEC_RD1: begin
				mul_start = 1'b1;
			end
			ST_SEC_M1: begin
				mul_start = mul_done;
			end
			ST_SEC_M2: begin
				tap_we = 1'b1;
				tap_waddr = {tbank, ch, sec_q, mul_done};
				tap_wdata = mul_done ? w2 : new_q;
			end
			ST_FADE_A: begin
				mul_start = 1'b1;
				mul_a = fch_q ? yc1_q : yc0_q;
				mul_b = 56'(mix_q);
				mul_sh = SH_FADE;
			end
			ST_FADE_B: begin
				mul_start = 1'b1;
				mul_a = fch_q ? yo1_q : yo0_q;
				mul_b = 56'(ONE_Q16 - mix_q);
				mul_sh = SH_FADE;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[coef_waddr] <= coef_wdata;
		end
		coef_rd_q <= coef_mem[coef_raddr];
	end

	always_ff @(posedge clk) begin
		if (tap_we) begin
			tap_mem[tap_waddr] <= tap_wdata;
		end
		tap_rd_q <= tap_mem[tap_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q <= '0;
			pass_q <= '0;
			sec_q <= '0;
			fch_q <= 1'b0;
			mode_q <= '0;
			frames_q <= 13'd512;
			step_q <= 16'd128;
			ramp_active_q <= 1'b0;
			ramp_count_q <= '0;
			mix_q <= '0;
			csel_q <= 1'b0;
			tsel_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_MODE: mode_q <= cfg_data[1:0];
					CFG_FRAMES: frames_q <= cfg_data[12:0];
					CFG_STEP: step_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd95) begin
						cnt_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						case (in_word.op)
							OP_FRAME: begin
								in_q <= in_word;
								pass_q <= 2'd0;
								state_q <= ST_GAIN_RD;
							end
							OP_APPLY: begin
								csel_q <= ~csel_q;
								tsel_q <= ~tsel_q;
								ramp_active_q <= 1'b1;
								ramp_count_q <= '0;
								mix_q <= '0;
								cnt_q <= '0;
								state_q <= ST_COPY;
							end
							default: begin
							end
						endcase
					end
				end
				ST_COPY: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd32) begin
						cnt_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_GAIN_RD: state_q <= ST_GAIN_MUL;
				ST_GAIN_MUL: state_q <= ST_GAIN_WAIT;
				ST_GAIN_WAIT: begin
					if (mul_done) begin
						x_q <= mul_res;
						sec_q <= '0;
						state_q <= ST_SEC_RD0;
					end
				end
				ST_SEC_RD0: state_q <= ST_SEC_RD1;
				ST_SEC_RD1: begin
					old_q <= tap_rd_q;
					state_q <= ST_SEC_M1;
				end
				ST_SEC_M1: begin
					if (mul_done) begin
						w_q <= w1;
						y_q <= y1;
						new_q <= tap_rd_q;
						state_q <= ST_SEC_M2;
					end
				end
				ST_SEC_M2: begin
					if (mul_done) begin
						x_q <= y2;
						if (sec_q == last_sec) begin
							case (pass_q)
								2'd0: yc0_q <= y2;
								2'd1: yc1_q <= y2;
								2'd2: yo0_q <= y2;
								default: yo1_q <= y2;
							endcase
							if (pass_q == 2'd1 && !ramp_active_q) begin
								state_q <= ST_OUT;
							end else if (pass_q == 2'd3) begin
								fch_q <= 1'b0;
								state_q <= ST_FADE_A;
							end else begin
								pass_q <= pass_q + 2'd1;
								state_q <= ST_GAIN_RD;
							end
						end else begin
							sec_q <= sec_q + 3'd1;
							state_q <= ST_SEC_RD0;
						end
					end
				end
				ST_FADE_A: state_q <= ST_FADE_AW;
				ST_FADE_AW: begin
					if (mul_done) begin
						a_q <= mul_res;
						state_q <= ST_FADE_B;
					end
				end
				ST_FADE_B: state_q <= ST_FADE_BW;
				ST_FADE_BW: begin
					if (mul_done) begin
						if (fch_q) begin
							yc1_q <= sat_tap(58'(a_q) + 58'(mul_res));
							mix_q <= (mix_sum > 18'(ONE_Q16)) ? ONE_Q16 : mix_sum[16:0];
							ramp_count_q <= count_next;
							if (count_next >= limit) begin
								ramp_active_q <= 1'b0;
							end
							state_q <= ST_OUT;
						end else begin
							yc0_q <= sat_tap(58'(a_q) + 58'(mul_res));
							fch_q <= 1'b1;
							state_q <= ST_FADE_A;
						end
					end
				end
				ST_OUT: begin
					// The previous word must be gone before this one is loaded.
					if (!out_valid_q || !out_stall) begin
						out_q.left_out <= to_sample(yc0_q);
						out_q.right_out <= to_sample(yc1_q);
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_word = out_q;
endmodule
`default_nettype wire

// ===== src/bbcx_mul.sv =====
// Shared multi-cycle signed multiplier: 56x56 magnitudes in four 28x28 partial products,
// then rounding half away from zero and saturation to 56 bits. Uses bbcx_pkg.
`default_nettype none
module bbcx_mul (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic signed [55:0]       a,
	input  wire logic signed [55:0]       b,
	input  wire bbcx_pkg::mshift_t        sh,
	output logic signed [55:0]            res,
	output logic                          done
);
	import bbcx_pkg::*;

	logic [55:0]   ma_q, mb_q;
	logic          neg_q;
	mshift_t       sh_q;
	logic [111:0]  acc_q;
	logic [1:0]    step_q;
	logic          active_q, fin_q, done_q;
	logic signed [55:0] res_q;

	logic [27:0]   pa, pb;
	logic [55:0]   prod;
	logic [111:0]  pp, rnd, r;
	logic          big;
	logic [55:0]   mag;

	always_comb begin
		pa = step_q[0] ? ma_q[55:28] : ma_q[27:0];
		pb = step_q[1] ? mb_q[55:28] : mb_q[27:0];
		prod = 56'(pa) * 56'(pb);
		case (step_q)
			2'd0: pp = {56'd0, prod};
			2'd3: pp = {prod, 56'd0};
			default: pp = {28'd0, prod, 28'd0};
		endcase
		if (sh_q == SH_FRAC) begin
			rnd = acc_q + (112'd1 << 43);
			r = rnd >> 44;
		end else begin
			rnd = acc_q + (112'd1 << 15);
			r = rnd >> 16;
		end
		big = neg_q ? (r > {56'd0, 56'h80000000000000}) : (r > {56'd0, 56'h7FFFFFFFFFFFFF});
		if (big) begin
			mag = neg_q ? 56'h80000000000000 : 56'h7FFFFFFFFFFFFF;
		end else begin
			mag = r[55:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				ma_q <= a[55] ? 56'(-a) : 56'(a);
				mb_q <= b[55] ? 56'(-b) : 56'(b);
				neg_q <= a[55] ^ b[55];
				sh_q <= sh;
				acc_q <= '0;
				step_q <= 2'd0;
				active_q <= 1'b1;
			end else if (active_q) begin
				acc_q <= acc_q + pp;
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					active_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
			if (fin_q) begin
				res_q <= neg_q ? -$signed(mag) : $signed(mag);
				fin_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign res = res_q;
	assign done = done_q;
endmodule
`default_nettype wire
